### src/crc16_command_frame_builder_core_assert.svh
// Assertion macros for the port-level checker.
`ifndef CRC16_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH
`define CRC16_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cfb_pkg.sv
// Package: frame constants, microcode word type, ROM and CRC byte function.
`timescale 1ns / 1ps

package cfb_pkg;

    localparam int unsigned STEP_W = 4;

    localparam logic [7:0]  START_LO_BYTE = 8'h55;
    localparam logic [7:0]  START_HI_BYTE = 8'h66;
    localparam logic [7:0]  CTRL_BYTE     = 8'h01;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_SEED      = 16'h0000;

    // Step numbers the program jumps to
    localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd10;

    typedef enum logic [3:0] {
        SEL_START_LO,
        SEL_START_HI,
        SEL_CTRL,
        SEL_LEN,
        SEL_ZERO,
        SEL_CMD,
        SEL_P0,
        SEL_P1,
        SEL_CRC_LO,
        SEL_CRC_HI
    } sel_t;

    typedef struct packed {
        sel_t              sel;        // byte source
        logic              crc_en;     // fold byte into CRC
        logic              last;       // final step of the program
        logic              jmp_short;  // jump when frame has one param
        logic [STEP_W-1:0] target;     // jump target
    } ctrl_t;

    typedef struct packed {
        logic  busy;
        ctrl_t word;
    } useq_status_t;

    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{sel: SEL_ZERO, crc_en: 1'b0, last: 1'b0, jmp_short: 1'b0,
              target: STEP_FIRST};
        case (step)
            4'd0:  begin w.sel = SEL_START_LO; w.crc_en = 1'b1; end
            4'd1:  begin w.sel = SEL_START_HI; w.crc_en = 1'b1; end
            4'd2:  begin w.sel = SEL_CTRL;     w.crc_en = 1'b1; end
            4'd3:  begin w.sel = SEL_LEN;      w.crc_en = 1'b1; end
            4'd4:  begin w.sel = SEL_ZERO;     w.crc_en = 1'b1; end
            4'd5:  begin w.sel = SEL_ZERO;     w.crc_en = 1'b1; end
            4'd6:  begin w.sel = SEL_ZERO;     w.crc_en = 1'b1; end
            4'd7:  begin w.sel = SEL_CMD;      w.crc_en = 1'b1; end
            4'd8:
            begin
                w.sel       = SEL_P0;
                w.crc_en    = 1'b1;
                w.jmp_short = 1'b1;
                w.target    = STEP_CRC_LO;
            end
            4'd9:  begin w.sel = SEL_P1;       w.crc_en = 1'b1; end
            4'd10: begin w.sel = SEL_CRC_LO; end
            4'd11: begin w.sel = SEL_CRC_HI;   w.last = 1'b1; end
            default: begin w.sel = SEL_CRC_HI; w.last = 1'b1; end
        endcase
        return w;
    endfunction

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### src/cfb_if.sv
// Handshake interfaces for the command and frame channels.
`timescale 1ns / 1ps

interface cfb_cmd_if;
    logic              valid;
    logic              ready;
    logic [7:0]        cmd_code;
    logic [1:0]        payload_count;
    logic signed [7:0] first_param;
    logic signed [7:0] second_param;

    modport source (output valid, cmd_code, payload_count, first_param, second_param,
                    input ready);
    modport sink   (input valid, cmd_code, payload_count, first_param, second_param,
                    output ready);
endinterface

interface cfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### src/cfb_crc.sv
// CRC-16 accumulator, one byte per enabled cycle.
`timescale 1ns / 1ps

module cfb_crc
    import cfb_pkg::*;
(
    input  logic        clk,
    input  logic        clear,
    input  logic        en,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (clear)
            crc_next = CRC_SEED;
        else if (en)
            crc_next = crc16_byte(crc_reg, data);
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

### src/cfb_useq.sv
// Microcode sequencer: step counter, control ROM, short-frame jump.
`timescale 1ns / 1ps

module cfb_useq
    import cfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         advance,
    input  logic         short_frame,
    output useq_status_t status
);

    logic [STEP_W-1:0] pc_reg, pc_next;
    logic              busy_reg, busy_next;
    ctrl_t             word;

    assign word = rom_word(pc_reg);

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = STEP_FIRST;
            busy_next = 1'b1;
        end
        else if (busy_reg && advance)
        begin
            if (word.last)
                busy_next = 1'b0;
            else if (word.jmp_short && short_frame)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_FIRST;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.word = word;

endmodule

### src/crc16_command_frame_builder_core.sv
// Top level: command frame builder with CRC-16 trailer.
//
//   channel | dir | words per frame | payload
//   --------+-----+-----------------+------------------------------------------
//   cmd     | in  | 1               | cmd_code, payload_count, first/second_param
//   frame   | out | 11 or 12        | frame_byte, last_byte
//
// A command is taken only while no frame is in progress; a frame of n bytes
// (11 with one parameter, 12 with two) is then built one control step per byte,
// each step loading one byte into the output register while it can take one.
// The next command can be taken once the last byte has entered the register.
// The output register lets a new command in while the final byte still waits.
// A stall on frame holds the sequencer on its current step; nothing is dropped.
// rst_n clears the sequencer and the output valid flag asynchronously.
`timescale 1ns / 1ps

module crc16_command_frame_builder_core
    import cfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    cfb_cmd_if.sink     cmd,
    cfb_frame_if.source frame
);

    // Latched command operands
    logic [7:0]   cmd_code_reg;
    logic [7:0]   p0_reg;
    logic [7:0]   p1_reg;
    logic         two_reg;       // two parameter bytes

    useq_status_t status;
    logic         cmd_fire;
    logic         slot_free;     // output register can take a byte
    logic         step_fire;     // sequencer emits a byte this cycle
    logic [7:0]   byte_sel;
    logic [15:0]  crc;

    // Output register
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;

    assign cmd.ready = !status.busy;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign slot_free = !out_valid_reg || frame.ready;
    assign step_fire = status.busy && slot_free;

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_code_reg <= cmd.cmd_code;
            p0_reg       <= cmd.first_param;
            p1_reg       <= cmd.second_param;
            two_reg      <= cmd.payload_count[1];  // bit 1 alone sets the size
        end
    end

    cfb_useq u_useq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd_fire),
        .advance     (slot_free),
        .short_frame (!two_reg),
        .status      (status)
    );

    // Byte source selected by the current control word
    always_comb
    begin
        case (status.word.sel)
            SEL_START_LO: byte_sel = START_LO_BYTE;
            SEL_START_HI: byte_sel = START_HI_BYTE;
            SEL_CTRL:     byte_sel = CTRL_BYTE;
            SEL_LEN:      byte_sel = {6'd0, two_reg, !two_reg};
            SEL_ZERO:     byte_sel = 8'h00;
            SEL_CMD:      byte_sel = cmd_code_reg;
            SEL_P0:       byte_sel = p0_reg;
            SEL_P1:       byte_sel = p1_reg;
            SEL_CRC_LO:   byte_sel = crc[7:0];
            SEL_CRC_HI:   byte_sel = crc[15:8];
            default:      byte_sel = 8'h00;
        endcase
    end

    cfb_crc u_crc (
        .clk   (clk),
        .clear (cmd_fire),
        .en    (step_fire && status.word.crc_en),
        .data  (byte_sel),
        .crc   (crc)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_fire)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= status.word.last;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.last_byte  = out_last_reg;

endmodule

### src/cfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
`timescale 1ns / 1ps
`include "crc16_command_frame_builder_core_assert.svh"

module cfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte
);

    `CFB_ASSERT_NEXT(a_cmd_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "cmd ready after accept")
    `CFB_ASSERT_NOW(a_idle_only_last_pending, cmd_ready && frame_valid, last_byte, "idle with mid-frame byte pending")
    `CFB_ASSERT_NEXT(a_frame_valid_holds, frame_valid && !frame_ready, frame_valid, "frame valid dropped under stall")
    `CFB_ASSERT_NEXT(a_frame_byte_holds, frame_valid && !frame_ready, $stable(frame_byte), "frame byte changed under stall")

endmodule

bind crc16_command_frame_builder_core cfb_checker u_cfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .last_byte   (frame.last_byte)
);

### tb/cfb_frame_checker.sv
// Frame checker: predicts each command's frame bytes and compares them with the output words.
`timescale 1ns / 1ps

module cfb_frame_checker
    import cfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfb_cmd_if          cmd,
    cfb_frame_if        frame,
    output int unsigned fail_count,
    output int unsigned bytes_due
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    frame_word_t expected_words[$];
    int unsigned mismatches = 0;
    int unsigned words_seen = 0;

    // bit-serial CRC-16, MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic queue_frame(input logic [7:0] code, input logic [1:0] count,
                               input logic [7:0] p0, input logic [7:0] p1);
        logic [7:0]  frm [12];
        int unsigned n;
        logic [15:0] crc;
        logic        two;
        two    = count[1];   // bit 1 alone picks the frame size
        frm[0] = START_LO_BYTE;
        frm[1] = START_HI_BYTE;
        frm[2] = CTRL_BYTE;
        frm[3] = two ? 8'd2 : 8'd1;
        frm[4] = 8'h00;
        frm[5] = 8'h00;
        frm[6] = 8'h00;
        frm[7] = code;
        frm[8] = p0;
        n      = 9;
        if (two)
        begin
            frm[9] = p1;
            n      = 10;
        end
        crc = CRC_SEED;
        for (int k = 0; k < n; k++)
            crc = crc_fold(crc, frm[k]);
        frm[n]     = crc[7:0];
        frm[n + 1] = crc[15:8];
        n          = n + 2;
        for (int k = 0; k < n; k++)
            expected_words.push_back('{data: frm[k], last: (k == n - 1)});
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] frame word %0d: %s", $realtime, words_seen, what);
    endtask

    always @(posedge clk)
    begin : watch
        frame_word_t want;
        if (rst_n)
        begin
            // output side first: a word leaving now belongs to an older command
            if (frame.valid && frame.ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word %02h last %0b",
                                              frame.frame_byte, frame.last_byte));
                else
                begin
                    want = expected_words.pop_front();
                    if (frame.frame_byte !== want.data)
                        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                  frame.frame_byte, want.data));
                    if (frame.last_byte !== want.last)
                        report_mismatch($sformatf("last_byte %0b, expected %0b",
                                                  frame.last_byte, want.last));
                end
                words_seen++;
            end
            if (cmd.valid && cmd.ready)
                queue_frame(cmd.cmd_code, cmd.payload_count, cmd.first_param,
                            cmd.second_param);
        end
        bytes_due  <= expected_words.size();
        fail_count <= mismatches;
    end

endmodule

### tb/tb_crc16_command_frame_builder_core.sv
// Testbench top: command stimulus, output back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module tb_crc16_command_frame_builder_core;

    // Longest correct quiet stretch is a sink stall or sender gap plus the time to
    // build a frame; this is many times that.
    localparam int unsigned IDLE_LIMIT  = 2000;
    // Frame of 12 bytes still needs time after accept; allow some slack.
    localparam int unsigned DRAIN_TAIL  = 24;
    localparam int unsigned RANDOM_CMDS = 100;

    logic clk;
    logic rst_n;

    cfb_cmd_if   cmd ();
    cfb_frame_if frame ();

    int unsigned fail_count;
    int unsigned bytes_due;
    int unsigned idle_cycles = 0;
    int unsigned sink_hold   = 0;
    bit          sender_steady;
    bit          sink_steady;

    crc16_command_frame_builder_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .frame (frame)
    );

    cfb_frame_checker frame_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .frame      (frame),
        .fail_count (fail_count),
        .bytes_due  (bytes_due)
    );

    always #4 clk = ~clk;

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sink side: random stalls on frame.ready, no new ones while sink_steady
    // is set. One assignment to ready per edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            frame.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            frame.ready <= 1'b0;
            sink_hold   <= sink_hold - 1;
        end
        else
        begin
            frame.ready <= 1'b1;
            if (!sink_steady)
                sink_hold <= pick_gap();
        end
    end

    // Watchdog: any accepted word on either channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (frame.valid && frame.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("tb_crc16_command_frame_builder_core failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one command and hold it until accepted. Called right after an
    // edge; returns at the accepting edge with valid still high, so a
    // back-to-back command keeps valid up without a low blip.
    task automatic send_cmd(input logic [7:0] code, input logic [1:0] count,
                            input logic signed [7:0] p0, input logic signed [7:0] p1);
        int unsigned gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.cmd_code      <= code;
        cmd.payload_count <= count;
        cmd.first_param   <= p0;
        cmd.second_param  <= p1;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    // Mostly legal sizes 1 and 2; the out-of-range 0 and 3 still get a share.
    task automatic send_random_cmd();
        int unsigned r;
        logic [1:0]  count;
        r = $urandom_range(0, 9);
        if (r < 4)
            count = 2'd1;
        else if (r < 8)
            count = 2'd2;
        else if (r == 8)
            count = 2'd0;
        else
            count = 2'd3;
        send_cmd(8'($urandom_range(0, 255)), count, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait for the checker's backlog to empty. The first
    // edge lets the just-accepted command show up in bytes_due.
    task automatic drain_frames();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cmd.valid         = 1'b0;
        cmd.cmd_code      = 8'h00;
        cmd.payload_count = 2'd1;
        cmd.first_param   = 8'sd0;
        cmd.second_param  = 8'sd0;
        frame.ready       = 1'b0;
        sender_steady     = 1'b0;
        sink_steady       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, both frame sizes, out-of-range counts.
        send_cmd(8'h00, 2'd1, 8'sd0,    8'sd0);
        send_cmd(8'hFF, 2'd2, 8'sd127,  8'sh80);
        send_cmd(8'hFF, 2'd1, 8'sh80,   8'sd127);
        send_cmd(8'h00, 2'd2, -8'sd1,   -8'sd1);
        send_cmd(8'h80, 2'd2, 8'sd0,    8'sd0);
        send_cmd(8'h7F, 2'd1, 8'sd127,  8'sd0);
        // count 0 builds a one-parameter frame, count 3 a two-parameter frame
        send_cmd(8'h5A, 2'd0, 8'sd33,   8'sd0);
        send_cmd(8'hA5, 2'd3, -8'sd77,  8'sd100);
        send_cmd(8'h00, 2'd0, -8'sd1,   8'sd127);
        send_cmd(8'h3C, 2'd3, 8'sh80,   8'sh80);
        // one-parameter frames that differ only in the unused second parameter
        send_cmd(8'hC3, 2'd1, 8'sd16,   -8'sd1);
        send_cmd(8'hC3, 2'd1, 8'sd16,   8'sd0);
        send_cmd(8'hC3, 2'd0, 8'sd16,   8'sh80);
        send_cmd(8'h01, 2'd1, -8'sd1,   8'sh80);
        send_cmd(8'hFF, 2'd2, -8'sd1,   -8'sd1);
        send_cmd(8'h55, 2'd2, 8'sh66,   8'sh55);
        send_cmd(8'hAA, 2'd3, 8'sd1,    8'sd2);

        // Hold off completely until every frame is out.
        drain_frames();

        // Random: phase 1 sender never idles, phase 2 sink never stalls.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_steady = (phase == 1);
            sink_steady  <= (phase == 2);
            repeat (RANDOM_CMDS) send_random_cmd();
            if (phase == 1)
                drain_frames();
        end
        sender_steady = 1'b0;
        sink_steady  <= 1'b0;

        drain_frames();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (fail_count == 0)
            $display("tb_crc16_command_frame_builder_core passed");
        else
            $display("tb_crc16_command_frame_builder_core failed");
        $finish;
    end

endmodule
